// File: rtl/pmd_pkg.sv
package pmd_pkg;

  localparam int POS_W      = 32;
  localparam int BOX_W      = 31;
  localparam int IDX_W      = 10;
  localparam int SQ_W       = 62;
  localparam int ROOT_W     = 31;
  localparam int DIFF_W     = 35;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [SQ_W-1:0]  SQ_MAX     = {SQ_W{1'b1}};
  localparam logic [BOX_W-1:0] BOX_RESET  = 31'd16777216;
  localparam logic [1:0]       DIMS_RESET = 2'd3;
  localparam logic [1:0]       DIMS_TWO   = 2'd2;

  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_MEASURE = 1'b1;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X,
    CFG_BOX_Y,
    CFG_BOX_Z,
    CFG_NUM_DIMS
  } cfg_reg_t;

  typedef struct packed {
    logic                    req_type;
    logic [IDX_W-1:0]        particle_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    last_particle;
  } pmd_in_t;

  typedef struct packed {
    logic [ROOT_W-1:0] peak_disp;
    logic              pass_kind;
  } pmd_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_FOLD,
    ST_SQ,
    ST_ACC,
    ST_MAX,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_EMIT
  } pmd_state_t;

endpackage

// File: rtl/periodic_max_displacement.sv
// Channel  Direction  Handshake          Request
// in_      input      in_valid/in_stall   pmd_in_t: capture or measure one particle
// out_     output     out_valid/out_stall pmd_out_t: result at the end of a pass
// cfg_     input      cfg_valid/cfg_ready register index and write data
// A capture request that ends a pass also waits in the emit state until the result slot is free.
// A measure request steps through the diff, fold, square, accumulate and max states, with
// the shared fold and square unit handling one component at a time.
// A request that ends a measure pass also runs the bit-serial square root.
// Reset is synchronous and active low; the reference memory is not cleared.
// A stalled result stays in the output register while the next request is accepted.
module periodic_max_displacement #(
  parameter int NUM_PARTICLES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pmd_pkg::pmd_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pmd_pkg::pmd_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW    = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
  localparam int PW    = pmd_pkg::POS_W;
  localparam int RAM_W = 3 * PW;
  localparam int DW    = pmd_pkg::DIFF_W;
  localparam int BW    = pmd_pkg::BOX_W;
  localparam int SW    = pmd_pkg::SQ_W;
  localparam int RW    = pmd_pkg::ROOT_W;

  pmd_pkg::pmd_state_t state_r, state_nxt;

  pmd_pkg::pmd_in_t        item_r;
  pmd_pkg::pmd_out_t       out_data_r;
  logic                    out_valid_r;
  logic [1:0]              comp_r;
  logic signed [DW-1:0]    d_r [3];
  logic [RW-1:0]           mag_r;
  logic                    sat_r;
  logic [SW-1:0]           sq_r;
  logic                    sq_sat_r;
  logic [SW-1:0]           sum_r;
  logic [SW-1:0]           max_r;
  logic [RW-1:0]           res_r;
  logic [BW-1:0]           box_r [3];
  logic [1:0]              dims_r;

  logic                    in_acc;
  logic                    cfg_acc;
  logic                    idx_ok;
  logic                    slot_free;
  logic                    last_comp;
  logic                    ram_we;
  logic                    ram_re;
  logic [AW-1:0]           ram_addr;
  logic [RAM_W-1:0]        ram_wdata;
  logic [RAM_W-1:0]        ram_rdata;
  logic signed [DW-1:0]    d_sel;
  logic signed [DW-1:0]    len_sel;
  logic signed [DW-1:0]    two_d;
  logic signed [DW-1:0]    fold;
  logic [DW-1:0]           fold_mag;
  logic [SW-1:0]           sq_prod;
  logic [SW:0]             sum_wide;
  logic                    root_start;
  logic                    root_done;
  logic [RW-1:0]           root_val;

  assign in_stall  = (state_r != pmd_pkg::ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign idx_ok    = 32'(in_data.particle_index) < 32'(NUM_PARTICLES);
  assign slot_free = ~out_valid_r | ~out_stall;

  assign ram_addr  = AW'(in_data.particle_index);
  assign ram_wdata = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign ram_we    = in_acc & (in_data.req_type == pmd_pkg::REQ_CAPTURE) & idx_ok;
  assign ram_re    = in_acc & (in_data.req_type == pmd_pkg::REQ_MEASURE);

  pmd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_PARTICLES)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  pmd_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (max_r),
    .done  (root_done),
    .root  (root_val)
  );

  assign root_start = (state_r == pmd_pkg::ST_ROOT_GO);
  assign last_comp  = (comp_r == pmd_pkg::COMP_Z) ||
                      ((comp_r == pmd_pkg::COMP_Y) && (dims_r == pmd_pkg::DIMS_TWO));

  always_comb begin
    d_sel    = d_r[comp_r];
    len_sel  = $signed({{(DW - BW){1'b0}}, box_r[comp_r]});
    two_d    = d_sel <<< 1;
    if (two_d >= len_sel) begin
      fold = d_sel - len_sel;
    end else if (two_d < -len_sel) begin
      fold = d_sel + len_sel;
    end else begin
      fold = d_sel;
    end
    fold_mag = fold[DW-1] ? DW'(-fold) : DW'(fold);
  end

  assign sq_prod  = mag_r * mag_r;
  assign sum_wide = {1'b0, sum_r} + {1'b0, sq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == pmd_pkg::REQ_CAPTURE) begin
            state_nxt = in_data.last_particle ? pmd_pkg::ST_EMIT : pmd_pkg::ST_IDLE;
          end else if (idx_ok) begin
            state_nxt = pmd_pkg::ST_DIFF;
          end else begin
            state_nxt = in_data.last_particle ? pmd_pkg::ST_ROOT_GO : pmd_pkg::ST_IDLE;
          end
        end
      end
      pmd_pkg::ST_DIFF:      state_nxt = pmd_pkg::ST_FOLD;
      pmd_pkg::ST_FOLD:      state_nxt = pmd_pkg::ST_SQ;
      pmd_pkg::ST_SQ:        state_nxt = pmd_pkg::ST_ACC;
      pmd_pkg::ST_ACC:       state_nxt = last_comp ? pmd_pkg::ST_MAX : pmd_pkg::ST_FOLD;
      pmd_pkg::ST_MAX: begin
        state_nxt = item_r.last_particle ? pmd_pkg::ST_ROOT_GO : pmd_pkg::ST_IDLE;
      end
      pmd_pkg::ST_ROOT_GO:   state_nxt = pmd_pkg::ST_ROOT_WAIT;
      pmd_pkg::ST_ROOT_WAIT: begin
        if (root_done) begin
          state_nxt = pmd_pkg::ST_EMIT;
        end
      end
      pmd_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = pmd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pmd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0] <= pmd_pkg::BOX_RESET;
      box_r[1] <= pmd_pkg::BOX_RESET;
      box_r[2] <= pmd_pkg::BOX_RESET;
      dims_r   <= pmd_pkg::DIMS_RESET;
    end else if (cfg_acc) begin
      unique case (pmd_pkg::cfg_reg_t'(cfg_index))
        pmd_pkg::CFG_BOX_X:    box_r[0] <= cfg_data[BW-1:0];
        pmd_pkg::CFG_BOX_Y:    box_r[1] <= cfg_data[BW-1:0];
        pmd_pkg::CFG_BOX_Z:    box_r[2] <= cfg_data[BW-1:0];
        pmd_pkg::CFG_NUM_DIMS: dims_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && (in_data.req_type == pmd_pkg::REQ_CAPTURE)) begin
        max_r <= '0;
      end else if ((state_r == pmd_pkg::ST_MAX) && (sum_r > max_r)) begin
        max_r <= sum_r;
      end else if ((state_r == pmd_pkg::ST_EMIT) && slot_free &&
                   (item_r.req_type == pmd_pkg::REQ_MEASURE)) begin
        max_r <= '0;
      end
      if ((state_r == pmd_pkg::ST_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
      res_r  <= '0;
    end
    if (state_r == pmd_pkg::ST_DIFF) begin
      d_r[0] <= DW'($signed(item_r.pos_x)) - DW'($signed(ram_rdata[PW-1:0]));
      d_r[1] <= DW'($signed(item_r.pos_y)) - DW'($signed(ram_rdata[2*PW-1:PW]));
      d_r[2] <= DW'($signed(item_r.pos_z)) - DW'($signed(ram_rdata[3*PW-1:2*PW]));
      sum_r  <= '0;
      comp_r <= pmd_pkg::COMP_X;
    end
    if (state_r == pmd_pkg::ST_FOLD) begin
      mag_r <= fold_mag[RW-1:0];
      sat_r <= |fold_mag[DW-1:RW];
    end
    if (state_r == pmd_pkg::ST_SQ) begin
      sq_r     <= sq_prod;
      sq_sat_r <= sat_r;
    end
    if (state_r == pmd_pkg::ST_ACC) begin
      sum_r  <= (sq_sat_r || sum_wide[SW]) ? pmd_pkg::SQ_MAX : sum_wide[SW-1:0];
      comp_r <= comp_r + 1'b1;
    end
    if ((state_r == pmd_pkg::ST_ROOT_WAIT) && root_done) begin
      res_r <= root_val;
    end
    if ((state_r == pmd_pkg::ST_EMIT) && slot_free) begin
      out_data_r.peak_disp <= res_r;
      out_data_r.pass_kind <= item_r.req_type;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/pmd_ram.sv
module pmd_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pmd_isqrt.sv
module pmd_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pmd_pkg::SQ_W-1:0]      value,
  output logic                          done,
  output logic [pmd_pkg::ROOT_W-1:0]    root
);

  localparam int RW    = pmd_pkg::ROOT_W;
  localparam int SW    = pmd_pkg::SQ_W;
  localparam int REM_W = RW + 2;
  localparam int SH_W  = REM_W + 2;
  localparam int CNT_W = $clog2(RW);

  logic [SW-1:0]    val_r;
  logic [REM_W-1:0] rem_r;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [SH_W-1:0]  rem_sh;
  logic [SH_W-1:0]  trial;
  logic [SH_W-1:0]  rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, val_r[SW-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[SW-3:0], 2'b00};
      rem_r  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: rtl/pmd_checker.sv
module pmd_checker #(
  parameter int NUM_PARTICLES = 1024
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input pmd_pkg::pmd_in_t                  in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input pmd_pkg::pmd_out_t                 out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [pmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [pmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic in_acc;
  logic meas_ok;

  assign in_acc  = in_valid & ~in_stall;
  assign meas_ok = (in_data.req_type == pmd_pkg::REQ_MEASURE) &&
                   (32'(in_data.particle_index) < 32'(NUM_PARTICLES));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_capture_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pass_kind == pmd_pkg::REQ_CAPTURE) |->
      (out_data.peak_disp == '0))
    else $error("Capture pass result is not zero.");

  a_measure_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && meas_ok |=> in_stall)
    else $error("Measure request did not hold off the next request.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready && (cfg_index == cfg_index) && (cfg_data == cfg_data))
    else $error("Configuration write was not taken.");

endmodule

bind periodic_max_displacement pmd_checker #(.NUM_PARTICLES(NUM_PARTICLES)) u_pmd_checker (.*);

// File: sim/periodic_max_displacement_tb.sv
`timescale 1ns / 100ps

module periodic_max_displacement_tb;
  import pmd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned PARTICLES = 1024;
  localparam int unsigned PHASE_REQUESTS = 250;
  localparam logic [63:0] SQ_CAP = {2'b00, SQ_MAX};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pmd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pmd_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = CFG_BOX_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  periodic_max_displacement dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  logic [POS_W-1:0] snap_x [PARTICLES];
  logic [POS_W-1:0] snap_y [PARTICLES];
  logic [POS_W-1:0] snap_z [PARTICLES];
  bit snap_written [PARTICLES];
  int captured_ids [$];
  int pass_members [$];

  logic [BOX_W-1:0] len_x = BOX_RESET;
  logic [BOX_W-1:0] len_y = BOX_RESET;
  logic [BOX_W-1:0] len_z = BOX_RESET;
  logic [1:0] dims = DIMS_RESET;
  logic [63:0] peak_sq = '0;

  pmd_out_t pass_results_due [$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned quiet_cycles = 0;
  bit steady_run = 1'b0;
  int unsigned stall_left = 0;
  bit stall_on = 1'b0;

  function automatic logic [63:0] folded_sq(logic signed [POS_W-1:0] p,
                                            logic signed [POS_W-1:0] r,
                                            logic [BOX_W-1:0] len);
    longint d;
    longint l;
    longint unsigned mag;
    d = longint'(p) - longint'(r);
    l = longint'({33'd0, len});
    if (2 * d >= l) begin
      d = d - l;
    end else if (2 * d < -l) begin
      d = d + l;
    end
    mag = (d < 0) ? -d : d;
    if (mag >= 64'h8000_0000) return SQ_CAP + 64'd1;
    return mag * mag;
  endfunction

  function automatic logic [63:0] capped_sum(logic [63:0] a, logic [63:0] b);
    if (a > SQ_CAP || b > SQ_CAP || a + b > SQ_CAP) return SQ_CAP;
    return a + b;
  endfunction

  function automatic logic [ROOT_W-1:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] probe;
    res = '0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res[ROOT_W-1:0];
  endfunction

  function automatic void model_displacement(pmd_in_t r);
    int idx;
    logic [63:0] sum;
    pmd_out_t due;
    idx = int'(r.particle_index);
    if (r.req_type == REQ_CAPTURE) begin
      if (!snap_written[idx]) captured_ids.push_back(idx);
      snap_written[idx] = 1'b1;
      snap_x[idx] = r.pos_x;
      snap_y[idx] = r.pos_y;
      snap_z[idx] = r.pos_z;
      peak_sq = '0;
    end else begin
      sum = capped_sum(folded_sq(r.pos_x, snap_x[idx], len_x),
                       folded_sq(r.pos_y, snap_y[idx], len_y));
      if (dims != DIMS_TWO) sum = capped_sum(sum, folded_sq(r.pos_z, snap_z[idx], len_z));
      if (sum > peak_sq) peak_sq = sum;
    end
    if (r.last_particle) begin
      due.pass_kind = r.req_type;
      if (r.req_type == REQ_CAPTURE) begin
        due.peak_disp = '0;
      end else begin
        due.peak_disp = root_floor(peak_sq);
        peak_sq = '0;
      end
      pass_results_due.push_back(due);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_run) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BOX_W-1:0] pick_len();
    logic [BOX_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = BOX_W'($urandom_range(1, 64));
      1: v = BOX_W'(1) << $urandom_range(8, 30);
      2: v = BOX_W'($urandom);
      default: v = BOX_W'($urandom_range(65536, 33554432));
    endcase
    if (v == 0) v = 1;
    return v;
  endfunction

  function automatic logic [POS_W-1:0] pick_delta(logic [BOX_W-1:0] len);
    longint span;
    longint off;
    longint unsigned r;
    span = (len == 0) ? 64'sd1024 : longint'({33'd0, len});
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: off = longint'($signed($urandom));
      1, 2: off = longint'($urandom_range(0, 512)) - 256;
      default: off = longint'(r % (2 * span + 1)) - span;
    endcase
    return POS_W'(off);
  endfunction

  function automatic pmd_in_t make_req(logic kind, int idx, logic [POS_W-1:0] x,
                                       logic [POS_W-1:0] y, logic [POS_W-1:0] z, bit last);
    pmd_in_t r;
    r.req_type = kind;
    r.particle_index = IDX_W'(idx);
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    r.last_particle = last;
    return r;
  endfunction

  function automatic pmd_in_t displaced_req(int idx, bit last);
    return make_req(REQ_MEASURE, idx, snap_x[idx] + pick_delta(len_x),
                    snap_y[idx] + pick_delta(len_y), snap_z[idx] + pick_delta(len_z), last);
  endfunction

  function automatic pmd_in_t random_capture(int idx, bit last);
    return make_req(REQ_CAPTURE, idx, $urandom, $urandom, $urandom, last);
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  task automatic send_request(pmd_in_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    model_displacement(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pass_results_due.size() != 0);
  endtask

  task automatic write_config(logic [BOX_W-1:0] bx, logic [BOX_W-1:0] by,
                              logic [BOX_W-1:0] bz, logic [CFG_DATA_W-1:0] nd);
    cfg_reg_t reg_id;
    logic [CFG_DATA_W-1:0] value;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      reg_id = cfg_reg_t'(i);
      case (reg_id)
        CFG_BOX_X: value = bx;
        CFG_BOX_Y: value = by;
        CFG_BOX_Z: value = bz;
        default: value = nd;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= reg_id;
      cfg_data <= value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (reg_id)
        CFG_BOX_X: len_x = value;
        CFG_BOX_Y: len_y = value;
        CFG_BOX_Z: len_z = value;
        default: dims = value[1:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      if (steady_run) begin
        stall_on = 1'b0;
        stall_left = 8;
      end else if (stall_on) begin
        stall_on = 1'b0;
        stall_left = $urandom_range(1, 12);
      end else begin
        stall_on = 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      end
    end else begin
      stall_left--;
    end
    out_stall <= stall_on;
  end

  always @(posedge clk) begin : check_results
    pmd_out_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (pass_results_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result disp=%h kind=%0d",
                                out_data.peak_disp, out_data.pass_kind));
      end else begin
        due = pass_results_due.pop_front();
        if (out_data.peak_disp !== due.peak_disp ||
            out_data.pass_kind !== due.pass_kind) begin
          note_mismatch($sformatf("expected disp=%h kind=%0d, got disp=%h kind=%0d",
                                  due.peak_disp, due.pass_kind,
                                  out_data.peak_disp, out_data.pass_kind));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Runs with the reset configuration; one measurement wraps across a box boundary.
  task automatic test_reset_config();
    send_request(make_req(REQ_CAPTURE, 0, 32'sh10000, 32'sh20000, 32'sh30000, 1'b0));
    send_request(make_req(REQ_CAPTURE, 1, -32'sh50000, 32'sh0, 32'sh8000, 1'b0));
    send_request(make_req(REQ_CAPTURE, 2, 32'sh640000, -32'sh10000, 32'sh0, 1'b0));
    send_request(make_req(REQ_CAPTURE, 3, 32'sh0, 32'sh0, 32'sh0, 1'b1));
    send_request(make_req(REQ_MEASURE, 0, 32'sh18000, 32'sh20000, 32'sh30000, 1'b0));
    send_request(make_req(REQ_MEASURE, 1, -32'sh50000, -32'sh18000, 32'sh8000, 1'b0));
    send_request(make_req(REQ_MEASURE, 2, -32'sh960000, -32'sh10000, 32'sh0, 1'b0));
    send_request(make_req(REQ_MEASURE, 3, 32'sh0, 32'sh0, 32'sh0, 1'b1));
  endtask

  task automatic test_extremes();
    write_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd3);
    send_request(make_req(REQ_CAPTURE, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_request(make_req(REQ_CAPTURE, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          1'b1));
    send_request(make_req(REQ_MEASURE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_request(make_req(REQ_MEASURE, 1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          1'b1));
    write_config(31'd1, 31'd1, 31'd1, 31'd3);
    send_request(make_req(REQ_CAPTURE, 5, 32'h0, 32'h0, 32'h0, 1'b1));
    send_request(make_req(REQ_MEASURE, 5, 32'sh1, -32'sh1, 32'sh0, 1'b1));
  endtask

  task automatic test_odd_box();
    write_config(31'd5, 31'd7, 31'd3, 31'd3);
    send_request(make_req(REQ_CAPTURE, 10, 32'h0, 32'h0, 32'h0, 1'b1));
    send_request(make_req(REQ_MEASURE, 10, 32'sh2, -32'sh3, 32'sh1, 1'b0));
    send_request(make_req(REQ_MEASURE, 10, 32'sh3, 32'sh3, -32'sh2, 1'b0));
    send_request(make_req(REQ_MEASURE, 10, -32'sh3, -32'sh4, 32'sh2, 1'b1));
  endtask

  // Two dimensions must ignore z; the unused codes behave as three dimensions.
  task automatic test_dimensions();
    write_config(BOX_RESET, BOX_RESET, BOX_RESET, CFG_DATA_W'(DIMS_TWO));
    send_request(make_req(REQ_CAPTURE, 20, 32'h0, 32'h0, 32'h0, 1'b1));
    send_request(make_req(REQ_MEASURE, 20, 32'sh100, 32'sh100, 32'h7FFF_FFFF, 1'b1));
    write_config(BOX_RESET, BOX_RESET, BOX_RESET, 31'd0);
    send_request(make_req(REQ_MEASURE, 20, 32'sh100, 32'sh100, 32'sh400000, 1'b1));
    write_config(BOX_RESET, BOX_RESET, BOX_RESET, 31'd1);
    send_request(make_req(REQ_MEASURE, 20, 32'sh100, 32'sh100, 32'sh400000, 1'b1));
  endtask

  task automatic test_zero_box();
    write_config(31'd0, 31'd0, 31'd0, 31'd3);
    send_request(make_req(REQ_CAPTURE, 30, 32'h0, 32'h0, 32'h0, 1'b1));
    send_request(make_req(REQ_MEASURE, 30, 32'sh10000, -32'sh10000, 32'sh20000, 1'b1));
    send_request(make_req(REQ_MEASURE, 30, 32'h8000_0000, 32'h0, 32'h0, 1'b1));
  endtask

  task automatic capture_pass();
    int n;
    int idx;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    pass_members.delete();
    for (int i = 0; i < n; i++) begin
      idx = $urandom_range(0, PARTICLES - 1);
      pass_members.push_back(idx);
      send_request(random_capture(idx, i == n - 1));
    end
  endtask

  // A broken pass has one capture request at a random position, which clears the maximum.
  task automatic measure_pass(bit broken);
    int n;
    int idx;
    int cut;
    n = $urandom_range(1, pass_members.size() + 2);
    cut = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      idx = pass_members[$urandom_range(0, pass_members.size() - 1)];
      if (broken && i == cut) begin
        send_request(random_capture(idx, i == n - 1));
      end else begin
        send_request(displaced_req(idx, i == n - 1));
      end
    end
  endtask

  task automatic noise_burst();
    int n;
    int idx;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0 || captured_ids.size() == 0) begin
        send_request(random_capture($urandom_range(0, PARTICLES - 1),
                                    1'($urandom_range(0, 1))));
      end else begin
        idx = captured_ids[$urandom_range(0, captured_ids.size() - 1)];
        send_request(displaced_req(idx, 1'($urandom_range(0, 1))));
      end
    end
  endtask

  task automatic test_random_passes();
    int unsigned phase_end;
    int unsigned roll;
    logic [CFG_DATA_W-1:0] nd;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0, 2: nd = {29'($urandom), DIMS_TWO};
        4: nd = {29'($urandom), 2'($urandom_range(0, 1))};
        default: nd = {29'($urandom), DIMS_RESET};
      endcase
      write_config(pick_len(), pick_len(), pick_len(), nd);
      phase_end = requests_sent + PHASE_REQUESTS;
      while (requests_sent < phase_end) begin
        steady_run = ($urandom_range(0, 5) == 0);
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
          capture_pass();
          repeat ($urandom_range(1, 3)) measure_pass(1'b0);
        end else if (roll < 9) begin
          noise_burst();
        end else begin
          capture_pass();
          measure_pass(1'b1);
        end
        if ($urandom_range(0, 7) == 0) drain_results();
      end
      steady_run = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_extremes();
    test_odd_box();
    test_dimensions();
    test_zero_box();
    test_random_passes();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pass_results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
